// ===== sv/oct_pkg.sv =====
// Package for the orthonormal color transform: widths, codes, payload types, coefficient table.
`timescale 1ns / 1ps
`default_nettype none

package oct_pkg;

   // Sample format and derived datapath widths
   localparam int SAMPLE_W = 16;
   localparam int N_CH     = 4;
   localparam int FRAC_W   = 16;                  // Q1.16 coefficients
   localparam int COEF_W   = FRAC_W + 2;          // signed, holds +1.0 for passthrough
   localparam int PROD_W   = SAMPLE_W + COEF_W;
   localparam int ACC_W    = PROD_W + 2;          // sum of four products
   localparam int RND_W    = ACC_W + 1 - FRAC_W;  // rounded sum before saturation

   localparam longint SAMPLE_MAX_L = (longint'(1) << (SAMPLE_W - 1)) - 1;
   localparam longint SAMPLE_MIN_L = -SAMPLE_MAX_L - 1;
   localparam logic signed [RND_W-1:0] RND_MAX = RND_W'(SAMPLE_MAX_L);
   localparam logic signed [RND_W-1:0] RND_MIN = RND_W'(SAMPLE_MIN_L);
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = SAMPLE_W'(SAMPLE_MAX_L);
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = SAMPLE_W'(SAMPLE_MIN_L);
   localparam logic signed [ACC_W:0] RND_HALF = (ACC_W + 1)'(longint'(1) << (FRAC_W - 1));

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_DIRECTION    = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_MODE = CSR_IDX_W'(1);

   localparam logic DIR_INVERSE = 1'b0;
   localparam logic DIR_FORWARD = 1'b1;

   typedef enum logic [1:0] {
      MODE_PASS  = 2'd0,
      MODE_THREE = 2'd1,
      MODE_BAYER = 2'd2
   } mode_type;

   // Q1.16 coefficients
   localparam logic signed [COEF_W-1:0] K_ONE  = COEF_W'(65536);
   localparam logic signed [COEF_W-1:0] K_A3   = COEF_W'(37837);
   localparam logic signed [COEF_W-1:0] K_S2   = COEF_W'(46341);
   localparam logic signed [COEF_W-1:0] K_S6   = COEF_W'(26755);
   localparam logic signed [COEF_W-1:0] K_S6X2 = COEF_W'(53510);
   localparam logic signed [COEF_W-1:0] K_H    = COEF_W'(32768);
   localparam logic signed [COEF_W-1:0] N_S2   = COEF_W'(-46341);
   localparam logic signed [COEF_W-1:0] N_S6X2 = COEF_W'(-53510);
   localparam logic signed [COEF_W-1:0] N_H    = COEF_W'(-32768);

   // Payload types
   typedef logic signed [SAMPLE_W-1:0] sample_word_type;

   typedef struct packed {
      sample_word_type sample_a;
      sample_word_type sample_b;
      sample_word_type sample_c;
      sample_word_type sample_d;
   } req_type;

   typedef struct packed {
      sample_word_type result_a;
      sample_word_type result_b;
      sample_word_type result_c;
      sample_word_type result_d;
      logic            clipped;
   } rsp_type;

   // Internal datapath vectors, index 0 is channel a
   typedef logic [N_CH-1:0][SAMPLE_W-1:0]          sample_vec_type;
   typedef logic [N_CH-1:0][N_CH-1:0][COEF_W-1:0]  coef_mat_type;   // [row][col]
   typedef logic [N_CH-1:0][N_CH-1:0][PROD_W-1:0]  prod_mat_type;   // [row][col]
   typedef logic [N_CH-1:0][1:0][ACC_W-1:0]        pair_vec_type;
   typedef logic [N_CH-1:0][ACC_W-1:0]             acc_vec_type;

   // Coefficient matrix for a direction and channel mode; passthrough is identity
   function automatic coef_mat_type coef_matrix(input logic fwd, input logic [1:0] mode);
      coef_mat_type m;
      m = '0;
      case (mode)
         MODE_THREE: begin
            if (fwd == DIR_FORWARD) begin
               m[0][0] = K_A3;  m[0][1] = K_A3;   m[0][2] = K_A3;
               m[1][0] = K_S2;                    m[1][2] = N_S2;
               m[2][0] = K_S6;  m[2][1] = N_S6X2; m[2][2] = K_S6;
            end else begin
               m[0][0] = K_A3;  m[0][1] = K_S2;   m[0][2] = K_S6;
               m[1][0] = K_A3;                    m[1][2] = N_S6X2;
               m[2][0] = K_A3;  m[2][1] = N_S2;   m[2][2] = K_S6;
            end
         end
         MODE_BAYER: begin
            if (fwd == DIR_FORWARD) begin
               m[0][0] = K_H;  m[0][1] = K_H;  m[0][2] = K_H;  m[0][3] = K_H;
                               m[1][1] = K_S2; m[1][2] = N_S2;
               m[2][0] = N_H;  m[2][1] = K_H;  m[2][2] = K_H;  m[2][3] = N_H;
               m[3][0] = N_S2;                                 m[3][3] = K_S2;
            end else begin
               m[0][0] = K_H;                  m[0][2] = N_H;  m[0][3] = N_S2;
               m[1][0] = K_H;  m[1][1] = K_S2; m[1][2] = K_H;
               m[2][0] = K_H;  m[2][1] = N_S2; m[2][2] = K_H;
               m[3][0] = K_H;                  m[3][2] = N_H;  m[3][3] = K_S2;
            end
         end
         default: begin
            m[0][0] = K_ONE; m[1][1] = K_ONE; m[2][2] = K_ONE; m[3][3] = K_ONE;
         end
      endcase
      return m;
   endfunction

endpackage

`default_nettype wire

// ===== sv/oct_mult.sv =====
// Product stage: sixteen sample-by-coefficient multiplies, registered.
`timescale 1ns / 1ps
`default_nettype none

module oct_mult (
   input  wire logic                  clock,
   input  wire logic                  load,
   input  wire oct_pkg::sample_vec_type samples,
   input  wire oct_pkg::coef_mat_type   coefs,
   output oct_pkg::prod_mat_type        prod_ff
);
   import oct_pkg::*;

   prod_mat_type prod_in;

   // one multiplier per matrix entry
   always_comb begin
      for (int r = 0; r < N_CH; r++) begin
         for (int c = 0; c < N_CH; c++) begin
            prod_in[r][c] = PROD_W'($signed(samples[c]) * $signed(coefs[r][c]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/oct_sum.sv =====
// Row sum stages: pairwise adds, then the full dot product, each registered.
`timescale 1ns / 1ps
`default_nettype none

module oct_sum (
   input  wire logic                 clock,
   input  wire logic                 load_pair,
   input  wire logic                 load_acc,
   input  wire oct_pkg::prod_mat_type prod,
   output oct_pkg::acc_vec_type       acc_ff
);
   import oct_pkg::*;

   pair_vec_type pair_in;
   pair_vec_type pair_ff;
   acc_vec_type  acc_in;

   // first level: columns 0+1 and 2+3 of each row
   always_comb begin
      for (int r = 0; r < N_CH; r++) begin
         pair_in[r][0] = ACC_W'($signed(prod[r][0])) + ACC_W'($signed(prod[r][1]));
         pair_in[r][1] = ACC_W'($signed(prod[r][2])) + ACC_W'($signed(prod[r][3]));
      end
   end

   // second level: full row sum
   always_comb begin
      for (int r = 0; r < N_CH; r++) begin
         acc_in[r] = pair_ff[r][0] + pair_ff[r][1];
      end
   end

   always_ff @(posedge clock) begin
      if (load_pair) begin
         pair_ff <= pair_in;
      end
      if (load_acc) begin
         acc_ff <= acc_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/oct_round.sv =====
// Output stage: round to nearest, saturate, flag clipping, register the result.
`timescale 1ns / 1ps
`default_nettype none

module oct_round (
   input  wire logic                clock,
   input  wire logic                load,
   input  wire oct_pkg::acc_vec_type acc,
   output oct_pkg::rsp_type          result_ff
);
   import oct_pkg::*;

   logic signed [ACC_W:0]      biased [N_CH];
   logic signed [RND_W-1:0]    rnd    [N_CH];
   logic [N_CH-1:0][SAMPLE_W-1:0] sat;
   logic [N_CH-1:0]            clip;
   rsp_type                    result_in;

   // add one half, floor shift, clamp to the sample range
   always_comb begin
      for (int r = 0; r < N_CH; r++) begin
         biased[r] = (ACC_W + 1)'($signed(acc[r])) + RND_HALF;
         rnd[r]    = $signed(biased[r][ACC_W:FRAC_W]);
         if (rnd[r] > RND_MAX) begin
            sat[r]  = SAMPLE_MAX;
            clip[r] = 1'b1;
         end else if (rnd[r] < RND_MIN) begin
            sat[r]  = SAMPLE_MIN;
            clip[r] = 1'b1;
         end else begin
            sat[r]  = rnd[r][SAMPLE_W-1:0];
            clip[r] = 1'b0;
         end
      end
   end

   always_comb begin
      result_in.result_a = sat[0];
      result_in.result_b = sat[1];
      result_in.result_c = sat[2];
      result_in.result_d = sat[3];
      result_in.clipped  = |clip;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/orthonormal_color_transform.sv =====
// Top level of the orthonormal color transform: registers, pipeline control, stages.
//
//  channel  direction  handshake            payload
//  req      in         req_valid/req_stall  req_data  (sample_a..sample_d)
//  rsp      out        rsp_valid/rsp_stall  rsp_data  (result_a..result_d, clipped)
//  csr      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// Five register stages: input/coefficient select, multiply, pair add, row sum,
// round and saturate. One transaction per cycle while rsp_stall is low.
// Each stage holds a valid bit and loads when empty or when the next stage moves,
// so bubbles are squeezed out and a stall on rsp holds everything in place.
// Reset (synchronous) clears the valid bits and sets forward, three-channel mode.
// csr_ready is always high; writes take effect on the next cycle.
`timescale 1ns / 1ps
`default_nettype none

module orthonormal_color_transform (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire oct_pkg::req_type                 req_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output oct_pkg::rsp_type                      rsp_data,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [oct_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [oct_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import oct_pkg::*;

   localparam int N_STAGE = 5;

   logic                 direction_ff;
   logic [1:0]           mode_ff;
   logic [N_STAGE:1]     vld_ff;
   logic [N_STAGE:1]     vld_in;
   logic [N_STAGE+1:1]   load;
   sample_vec_type       samp_ff;
   sample_vec_type       samp_in;
   coef_mat_type         coef_ff;
   prod_mat_type         prod;
   acc_vec_type          acc;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= DIR_FORWARD;
         mode_ff      <= MODE_THREE;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DIRECTION:    direction_ff <= csr_wdata[0];
            CSR_CHANNEL_MODE: mode_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stage load enables: a stage moves when empty or when its successor moves
   always_comb begin
      load[N_STAGE+1] = !rsp_stall;
      for (int k = N_STAGE; k >= 1; k--) begin
         load[k] = !vld_ff[k] || load[k+1];
      end
   end

   always_comb begin
      vld_in[1] = load[1] ? req_valid : vld_ff[1];
      for (int k = 2; k <= N_STAGE; k++) begin
         vld_in[k] = load[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_stall = !load[1];
   assign rsp_valid = vld_ff[N_STAGE];

   // stage 1: capture samples and the coefficient set
   always_comb begin
      samp_in[0] = req_data.sample_a;
      samp_in[1] = req_data.sample_b;
      samp_in[2] = req_data.sample_c;
      samp_in[3] = req_data.sample_d;
   end

   always_ff @(posedge clock) begin
      if (load[1]) begin
         samp_ff <= samp_in;
         coef_ff <= coef_matrix(direction_ff, mode_ff);
      end
   end

   // stage 2: products
   oct_mult u_mult (
      .clock   (clock),
      .load    (load[2]),
      .samples (samp_ff),
      .coefs   (coef_ff),
      .prod_ff (prod)
   );

   // stages 3 and 4: row sums
   oct_sum u_sum (
      .clock     (clock),
      .load_pair (load[3]),
      .load_acc  (load[4]),
      .prod      (prod),
      .acc_ff    (acc)
   );

   // stage 5: round, saturate, output register
   oct_round u_round (
      .clock     (clock),
      .load      (load[5]),
      .acc       (acc),
      .result_ff (rsp_data)
   );

   // input is held off only when every stage is full and the output is stalled
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&vld_ff) && rsp_stall)
      else $error("input stalled while the pipeline has room");

   // a clipped result has at least one channel at a range bound
   a_clip_at_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.clipped |->
         rsp_data.result_a == SAMPLE_MAX || rsp_data.result_a == SAMPLE_MIN ||
         rsp_data.result_b == SAMPLE_MAX || rsp_data.result_b == SAMPLE_MIN ||
         rsp_data.result_c == SAMPLE_MAX || rsp_data.result_c == SAMPLE_MIN ||
         rsp_data.result_d == SAMPLE_MAX || rsp_data.result_d == SAMPLE_MIN)
      else $error("clip flag set without a saturated channel");

   // an output transaction that is taken is replaced or the stage empties
   a_output_drains: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !vld_ff[N_STAGE-1] |=> !rsp_valid)
      else $error("output transaction repeated");

endmodule

`default_nettype wire

// ===== test/tb_orthonormal_color_transform.sv =====
// Self-checking testbench for the orthonormal color transform: directed and random pixels.
`timescale 1ns / 1ps

module tb_orthonormal_color_transform;
   import oct_pkg::*;

   // Q1.16 coefficients of the predictor
   localparam longint Q_ISQ3  = 37837;   // 1/sqrt3
   localparam longint Q_ISQ2  = 46341;   // 1/sqrt2
   localparam longint Q_ISQ6  = 26755;   // 1/sqrt6
   localparam longint Q_ISQ6D = 53510;   // 2/sqrt6
   localparam longint Q_HALF  = 32768;   // 1/2

   // Sample bounds as plain integers for the stimulus tasks
   localparam int S_MAX_I = int'(SAMPLE_MAX_L);
   localparam int S_MIN_I = int'(SAMPLE_MIN_L);

   // Register codes the package leaves unnamed
   localparam logic [1:0] MODE_SPARE = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_2 = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_3 = CSR_IDX_W'(3);

   localparam int SETTLE_CYCLES = 8;      // pipeline depth plus margin
   localparam int IDLE_LIMIT    = 3000;   // cycles without any transaction
   localparam int LONG_HOLD     = 300;
   localparam int MAX_PRINTED   = 100;

   logic     clock;
   logic     reset;
   logic     req_valid;
   logic     req_stall;
   req_type  req_data;
   logic     rsp_valid;
   logic     rsp_stall;
   rsp_type  rsp_data;
   logic     csr_valid;
   logic     csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // Predictor copy of the registers
   logic       cfg_dir;
   logic [1:0] cfg_mode;

   rsp_type pending_pixels[$];

   int error_count;
   int pixels_sent;
   int pixels_checked;
   int clipped_count;
   int settings_used;
   int input_stall_cycles;
   int idle_cycles;

   // Sender and receiver pacing knobs
   int gap_max;
   int burst_left;
   int stall_pct;
   int hold_len;
   int hold_seq;
   int hold_seen;
   int hold_left;
   int stall_run;
   bit stall_now;

   orthonormal_color_transform i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- prediction

   // Round to nearest (ties up), then clamp to the sample range
   function automatic sample_word_type round_sat(input longint acc, inout logic sat);
      longint r;
      r = (acc + 64'sd32768) >>> 16;
      if (r > SAMPLE_MAX_L) begin
         r = SAMPLE_MAX_L;
         sat = 1'b1;
      end else if (r < SAMPLE_MIN_L) begin
         r = SAMPLE_MIN_L;
         sat = 1'b1;
      end
      return r[SAMPLE_W-1:0];
   endfunction

   function automatic rsp_type transform_pixel(input req_type px);
      longint  a, b, c, d;
      longint  acc [4];
      logic    sat;
      rsp_type o;
      a = longint'(px.sample_a);
      b = longint'(px.sample_b);
      c = longint'(px.sample_c);
      d = longint'(px.sample_d);
      sat = 1'b0;
      if (cfg_mode == MODE_THREE && cfg_dir == DIR_FORWARD) begin
         acc[0] = Q_ISQ3 * (a + b + c);
         acc[1] = Q_ISQ2 * (a - c);
         acc[2] = Q_ISQ6 * a - Q_ISQ6D * b + Q_ISQ6 * c;
         acc[3] = 0;
      end else if (cfg_mode == MODE_THREE) begin
         acc[0] = Q_ISQ3 * a + Q_ISQ2 * b + Q_ISQ6 * c;
         acc[1] = Q_ISQ3 * a - Q_ISQ6D * c;
         acc[2] = Q_ISQ3 * a - Q_ISQ2 * b + Q_ISQ6 * c;
         acc[3] = 0;
      end else if (cfg_mode == MODE_BAYER && cfg_dir == DIR_FORWARD) begin
         acc[0] = Q_HALF * (a + b + c + d);
         acc[1] = Q_ISQ2 * (b - c);
         acc[2] = Q_HALF * (b + c - a - d);
         acc[3] = Q_ISQ2 * (d - a);
      end else if (cfg_mode == MODE_BAYER) begin
         acc[0] = Q_HALF * (a - c) - Q_ISQ2 * d;
         acc[1] = Q_HALF * (a + c) + Q_ISQ2 * b;
         acc[2] = Q_HALF * (a + c) - Q_ISQ2 * b;
         acc[3] = Q_HALF * (a - c) + Q_ISQ2 * d;
      end else begin
         // passthrough, including the spare mode code
         o.result_a = px.sample_a;
         o.result_b = px.sample_b;
         o.result_c = px.sample_c;
         o.result_d = px.sample_d;
         o.clipped  = 1'b0;
         return o;
      end
      o.result_a = round_sat(acc[0], sat);
      o.result_b = round_sat(acc[1], sat);
      o.result_c = round_sat(acc[2], sat);
      o.result_d = round_sat(acc[3], sat);
      o.clipped  = sat;
      return o;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_error(input string msg);
      error_count++;
      if (error_count <= MAX_PRINTED)
         $display("ERROR @%0t: %s", $time, msg);
   endtask

   task automatic check_sample(input string field, input sample_word_type got,
                               input sample_word_type want);
      if (got !== want)
         report_error($sformatf("pixel %0d %s: got %0d, expected %0d",
                                pixels_checked, field, got, want));
   endtask

   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pixels.size() == 0) begin
            report_error("result transaction with no pixel outstanding");
         end else begin
            want = pending_pixels.pop_front();
            check_sample("result_a", rsp_data.result_a, want.result_a);
            check_sample("result_b", rsp_data.result_b, want.result_b);
            check_sample("result_c", rsp_data.result_c, want.result_c);
            check_sample("result_d", rsp_data.result_d, want.result_d);
            if (rsp_data.clipped !== want.clipped)
               report_error($sformatf("pixel %0d clipped: got %b, expected %b",
                                      pixels_checked, rsp_data.clipped, want.clipped));
            if (want.clipped)
               clipped_count++;
            pixels_checked++;
         end
      end
   end

   // Watchdog: ends the run when no transaction moves for too long
   always @(posedge clock) begin
      if (req_valid && req_stall)
         input_stall_cycles++;
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout after %0d idle cycles, %0d results outstanding",
                  idle_cycles, pending_pixels.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles++;
      end
   end

   // ---------------------------------------------------------------- receiver

   // Stall runs of random length; a long hold when requested
   initial begin
      rsp_stall = 1'b0;
      hold_seen = 0;
      hold_left = 0;
      stall_run = 0;
      stall_now = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_seen != hold_seq) begin
            hold_seen = hold_seq;
            hold_left = hold_len;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_pct == 0) begin
            rsp_stall <= 1'b0;
         end else begin
            if (stall_run == 0) begin
               stall_now = ($urandom_range(99) < stall_pct);
               stall_run = $urandom_range(1, 8);
            end
            stall_run--;
            rsp_stall <= stall_now;
         end
      end
   end

   // ---------------------------------------------------------------- sender

   task automatic send_pixel(input req_type px);
      int gap;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= px;
      do @(posedge clock); while (req_stall);
      pending_pixels.push_back(transform_pixel(px));
      pixels_sent++;
      // bursts separated by random gaps
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 16);
         if (gap_max > 0) begin
            gap = $urandom_range(1, gap_max);
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
   endtask

   task automatic send_samples(input int a, input int b, input int c, input int d);
      req_type px;
      px.sample_a = a[SAMPLE_W-1:0];
      px.sample_b = b[SAMPLE_W-1:0];
      px.sample_c = c[SAMPLE_W-1:0];
      px.sample_d = d[SAMPLE_W-1:0];
      send_pixel(px);
   endtask

   // Extremes, small values that stay in range, and full-range values
   function automatic sample_word_type pick_sample();
      int v;
      case ($urandom_range(7))
         0:       v = S_MAX_I;
         1:       v = S_MIN_I;
         2, 3:    v = int'($urandom_range(4095)) - 2048;
         default: v = $urandom();
      endcase
      return v[SAMPLE_W-1:0];
   endfunction

   function automatic req_type random_pixel();
      req_type px;
      px.sample_a = pick_sample();
      px.sample_b = pick_sample();
      px.sample_c = pick_sample();
      px.sample_d = pick_sample();
      return px;
   endfunction

   // Stop offering and wait until every result is back and the pipe is empty
   task automatic drain_pipeline();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_DIRECTION:    cfg_dir  = val[0];
         CSR_CHANNEL_MODE: cfg_mode = val;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Direction goes with a random upper bit, which the block must ignore
   task automatic set_config(input logic dir, input logic [1:0] mode);
      write_reg(CSR_CHANNEL_MODE, mode);
      write_reg(CSR_DIRECTION, {1'($urandom_range(1)), dir});
      settings_used++;
   endtask

   // ---------------------------------------------------------------- tests

   // Reset settings are forward three-channel
   task automatic test_reset_config();
      send_samples(S_MAX_I, S_MAX_I, S_MAX_I, S_MAX_I);
      send_samples(S_MIN_I, S_MIN_I, S_MIN_I, S_MIN_I);
      send_samples(S_MAX_I, S_MIN_I, S_MAX_I, S_MIN_I);
      send_samples(0, 0, 0, 0);
      drain_pipeline();
   endtask

   // Every mode and direction, with saturation and rounding ties
   task automatic test_each_setting();
      logic [1:0] mode;
      for (int m = 0; m < 4; m++) begin
         for (int dir = 0; dir < 2; dir++) begin
            mode = m[1:0];
            set_config(dir[0], mode);
            send_samples(S_MIN_I, S_MAX_I, S_MIN_I, S_MAX_I);
            send_pixel(random_pixel());
            if (mode == MODE_BAYER && dir[0] == DIR_FORWARD) begin
               // half-LSB cases, ties go up
               send_samples(1, 0, 0, 0);
               send_samples(-1, 0, 0, 0);
            end else if (mode == MODE_BAYER) begin
               send_samples(-1, 0, 0, 0);
               send_samples(1, 0, 1, 0);
            end
            drain_pipeline();
         end
      end
   endtask

   // Writes to unused register indexes change nothing
   task automatic test_unused_index();
      set_config(DIR_FORWARD, MODE_BAYER);
      write_reg(CSR_UNUSED_2, CSR_DATA_W'($urandom_range(3)));
      write_reg(CSR_UNUSED_3, CSR_DATA_W'($urandom_range(3)));
      send_samples(1000, -2000, 3000, -4000);
      drain_pipeline();
   endtask

   // Long receiver hold while the sender keeps offering, then a full drain
   task automatic test_backpressure();
      set_config(DIR_FORWARD, MODE_THREE);
      gap_max   = 0;
      stall_pct = 0;
      hold_len  = LONG_HOLD;
      hold_seq++;
      repeat (40) send_pixel(random_pixel());
      drain_pipeline();
      repeat (20) send_pixel(random_pixel());
      drain_pipeline();
   endtask

   // Phases of random pixels, each under its own setting and pacing
   task automatic test_random_stream();
      int count;
      for (int phase = 0; phase < 12; phase++) begin
         if (phase < 8)
            set_config(phase[0], phase[2:1]);
         else
            set_config(1'($urandom_range(1)), 2'($urandom_range(MODE_SPARE)));
         case (phase % 3)
            0: begin gap_max = 0;  stall_pct = 0;  end
            1: begin gap_max = 4;  stall_pct = 25; end
            default: begin gap_max = 12; stall_pct = 60; end
         endcase
         count = $urandom_range(60, 100);
         repeat (count) send_pixel(random_pixel());
         drain_pipeline();
      end
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      cfg_dir     = DIR_FORWARD;
      cfg_mode    = MODE_THREE;
      error_count = 0;
      pixels_sent = 0;
      pixels_checked = 0;
      clipped_count  = 0;
      settings_used  = 1;
      input_stall_cycles = 0;
      idle_cycles = 0;
      gap_max     = 0;
      burst_left  = 0;
      stall_pct   = 0;
      hold_len    = 0;
      hold_seq    = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_config();
      test_each_setting();
      test_unused_index();
      test_backpressure();
      test_random_stream();

      drain_pipeline();
      if (pending_pixels.size() != 0)
         report_error($sformatf("%0d results never arrived", pending_pixels.size()));
      $display("Sent %0d pixels under %0d register settings; %0d results checked, %0d saturated.",
               pixels_sent, settings_used, pixels_checked, clipped_count);
      $display("Input held off for %0d cycles; %0d mismatches.", input_stall_cycles, error_count);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/oct_pkg.sv
sv/oct_mult.sv
sv/oct_sum.sv
sv/oct_round.sv
sv/orthonormal_color_transform.sv
test/tb_orthonormal_color_transform.sv
